// ===== rtl/hsl_pkg.sv =====
// shared types and constants for the hsl saturation adjust block
`timescale 1ns / 1ps
package hsl_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int PCT_MAX       = 100;
  // floor(x / 25) == (x * 5243) >> 17 for x below 19200
  localparam logic [12:0] RECIP25 = 13'd5243;
  localparam int RECIP_SHIFT   = 17;

  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
  } pix_out_t;

  // per-pixel side data carried along the pipeline
  typedef struct packed {
    pix_in_t    pix;
    logic [8:0] sum;
    logic       gray;
    logic       neg;
    logic [6:0] pmag;
  } ctx_t;

  // controls shared by the three channel lanes
  typedef struct packed {
    logic [8:0] sum;
    logic       neg;
    logic [6:0] pmag;
  } lane_ctl_t;

endpackage

// ===== rtl/hsl_lane.sv =====
// one channel lane: deviation scaling, truncating division and clamping
`timescale 1ns / 1ps
module hsl_lane #(
  parameter int FracBits = hsl_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [7:0]            c_i,
  input  hsl_pkg::lane_ctl_t    ctl_i,
  input  logic [FracBits+9:0]   gain_i,
  output logic [7:0]            res_o
);
  import hsl_pkg::*;

  localparam int PW = FracBits + 22;

  logic signed [10:0]   dev;
  logic signed [PW-1:0] prod;
  logic signed [19:0]   nn;
  logic [6:0]           kf;

  logic signed [PW-1:0] prod_q;
  logic signed [19:0]   nn_q;
  logic [7:0]           c_q;
  logic                 neg_q;

  logic signed [PW:0]   pos_num;
  logic signed [PW:0]   pos_sh;
  logic [13:0]          nx;
  logic [26:0]          nprod;
  logic [9:0]           nq;
  logic [7:0]           res_d;
  logic [7:0]           res_q;

  // signed deviation from lightness and both branch numerators
  assign dev  = $signed({2'b00, c_i, 1'b0}) - $signed({2'b00, ctl_i.sum});
  assign prod = PW'(dev) * $signed(PW'({1'b0, gain_i}));
  assign kf   = 7'(PCT_MAX) - ctl_i.pmag;
  assign nn   = $signed(20'(ctl_i.sum)) * 20'sd100 + 20'(dev) * $signed(20'(kf));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod;
      nn_q   <= nn;
      c_q    <= c_i;
      neg_q  <= ctl_i.neg;
    end
  end

  // final add, divide and clamp
  assign pos_num = $signed((PW+1)'({c_q, {(FracBits+1){1'b0}}})) + (PW+1)'(prod_q);
  assign pos_sh  = pos_num >>> (FracBits + 1);
  assign nx      = nn_q[16:3];
  assign nprod   = 27'(nx) * 27'(RECIP25);
  assign nq      = nprod[RECIP_SHIFT+9:RECIP_SHIFT];

  always_comb begin
    res_d = 8'd0;
    if (neg_q) begin
      if (nn_q <= 20'sd0)   res_d = 8'd0;
      else if (nq >= 10'd255) res_d = 8'd255;
      else                  res_d = nq[7:0];
    end else begin
      if (pos_num <= 0)                   res_d = 8'd0;
      else if (pos_sh >= (PW+1)'(255))    res_d = 8'd255;
      else                                res_d = pos_sh[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/hsl_saturation_adjust.sv =====
// top level of the hsl saturation adjust pipeline
`timescale 1ns / 1ps
// HSL saturation adjust. Takes one RGB pixel word per clock and returns one adjusted word
// per clock unless a held output word stalls it. Each word passes through 3*FracBits+7
// register stages: an input register, a bit-serial pipelined divider for the saturation S
// (FracBits+1 stages), an alpha register, a pipelined divider for the gain 1/alpha
// (2*FracBits+1 stages), two lane stages and the output register. The percent fraction
// comes from a constant table. Three identical channel lanes scale each channel and a
// merge stage selects gray passthrough. A stall on a valid output word freezes the whole
// pipeline and is seen on in_stall_o in the same cycle. The percent register may only be
// written while the pipeline is empty.
module hsl_saturation_adjust #(
  parameter int FracBits = hsl_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hsl_pkg::pix_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hsl_pkg::pix_out_t out_word_o
);
  import hsl_pkg::*;

  localparam int SDIV = FracBits + 1;
  localparam int GDIV = 2 * FracBits + 1;
  localparam int QW   = FracBits + 1;
  localparam int GW   = FracBits + 10;
  localparam int RW   = FracBits + 2;
  localparam int CW   = FracBits + 8;

  logic en;
  logic signed [7:0] pct_q;
  logic signed [7:0] pct_c;
  logic [6:0] pmag;

  // pipeline advances unless the output word is held
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // percent register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q <= 8'sd0;
    end else if (cfg_we_i) begin
      pct_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (pct_q > 8'sd100)       pct_c = 8'sd100;
    else if (pct_q < -8'sd100) pct_c = -8'sd100;
    else                       pct_c = pct_q;
  end
  assign pmag = pct_c[7] ? 7'(-pct_c) : pct_c[6:0];

  // max, min, sum and denominator of the input pixel
  logic [7:0] mx, mn, den;
  logic [8:0] sum;
  ctx_t       ctx_in;

  always_comb begin
    mx = in_word_i.red_in;
    mn = in_word_i.red_in;
    if (in_word_i.green_in > mx) mx = in_word_i.green_in;
    if (in_word_i.blue_in  > mx) mx = in_word_i.blue_in;
    if (in_word_i.green_in < mn) mn = in_word_i.green_in;
    if (in_word_i.blue_in  < mn) mn = in_word_i.blue_in;
    sum = {1'b0, mx} + {1'b0, mn};
    den = (sum < 9'd255) ? sum[7:0] : 8'(10'd510 - {1'b0, sum});
    ctx_in.pix  = in_word_i;
    ctx_in.sum  = sum;
    ctx_in.gray = (mx == mn);
    ctx_in.neg  = pct_c[7];
    ctx_in.pmag = pmag;
  end

  // saturation divider, one quotient bit per stage
  logic          s_v_q   [0:SDIV];
  ctx_t          s_ctx_q [0:SDIV];
  logic [8:0]    s_rem_q [0:SDIV];
  logic [7:0]    s_den_q [0:SDIV];
  logic [QW-1:0] s_quo_q [0:SDIV];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q[0] <= 1'b0;
    end else if (en) begin
      s_v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_ctx_q[0] <= ctx_in;
      s_rem_q[0] <= {1'b0, mx - mn};
      s_den_q[0] <= den;
      s_quo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < SDIV; k++) begin : g_sdiv
    logic [8:0] rs;
    logic       s_ge;

    assign rs   = (k == 0) ? s_rem_q[k] : {s_rem_q[k][7:0], 1'b0};
    assign s_ge = rs >= {1'b0, s_den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_v_q[k+1] <= 1'b0;
      end else if (en) begin
        s_v_q[k+1] <= s_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        s_ctx_q[k+1] <= s_ctx_q[k];
        s_den_q[k+1] <= s_den_q[k];
        s_rem_q[k+1] <= s_ge ? rs - {1'b0, s_den_q[k]} : rs;
        s_quo_q[k+1] <= {s_quo_q[k][QW-2:0], s_ge};
      end
    end
  end

  // percent as a fraction, constant table over 0..100
  logic [QW-1:0] pfrac;

  always_comb begin
    pfrac = '0;
    for (int k = 0; k <= PCT_MAX; k++) begin
      if (s_ctx_q[SDIV].pmag == 7'(k)) pfrac = QW'((longint'(k) <<< FracBits) / PCT_MAX);
    end
  end

  // alpha select
  logic [CW-1:0] lhs;
  logic [QW-1:0] alpha;

  always_comb begin
    lhs = CW'({s_ctx_q[SDIV].pmag, {FracBits{1'b0}}})
        + CW'(s_quo_q[SDIV]) * CW'(PCT_MAX);
    if (lhs >= CW'({7'(PCT_MAX), {FracBits{1'b0}}})) alpha = s_quo_q[SDIV];
    else alpha = {1'b1, {FracBits{1'b0}}} - pfrac;
    if (alpha == '0) alpha = QW'(1);
  end

  // gain divider 2^(2F) / alpha, one quotient bit per stage
  logic          g_v_q   [0:GDIV];
  ctx_t          g_ctx_q [0:GDIV];
  logic [RW-1:0] g_rem_q [0:GDIV];
  logic [QW-1:0] g_den_q [0:GDIV];
  logic [GW-1:0] g_quo_q [0:GDIV];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q[0] <= 1'b0;
    end else if (en) begin
      g_v_q[0] <= s_v_q[SDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_ctx_q[0] <= s_ctx_q[SDIV];
      g_rem_q[0] <= '0;
      g_den_q[0] <= alpha;
      g_quo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < GDIV; k++) begin : g_gdiv
    logic [RW-1:0] rs;
    logic          ge;

    assign rs = {g_rem_q[k][RW-2:0], (k == 0) ? 1'b1 : 1'b0};
    assign ge = rs >= {1'b0, g_den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        g_v_q[k+1] <= 1'b0;
      end else if (en) begin
        g_v_q[k+1] <= g_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        g_ctx_q[k+1] <= g_ctx_q[k];
        g_den_q[k+1] <= g_den_q[k];
        g_rem_q[k+1] <= ge ? rs - {1'b0, g_den_q[k]} : rs;
        g_quo_q[k+1] <= {g_quo_q[k][GW-2:0], ge};
      end
    end
  end

  // channel lanes
  logic [GW-1:0] gain;
  lane_ctl_t     lctl;
  logic [7:0]    res_b, res_g, res_r;

  assign gain      = g_quo_q[GDIV] - GW'({1'b1, {FracBits{1'b0}}});
  assign lctl.sum  = g_ctx_q[GDIV].sum;
  assign lctl.neg  = g_ctx_q[GDIV].neg;
  assign lctl.pmag = g_ctx_q[GDIV].pmag;

  hsl_lane #(.FracBits(FracBits)) u_lane_b (
    .clk_i, .en_i(en), .c_i(g_ctx_q[GDIV].pix.blue_in), .ctl_i(lctl), .gain_i(gain),
    .res_o(res_b)
  );
  hsl_lane #(.FracBits(FracBits)) u_lane_g (
    .clk_i, .en_i(en), .c_i(g_ctx_q[GDIV].pix.green_in), .ctl_i(lctl), .gain_i(gain),
    .res_o(res_g)
  );
  hsl_lane #(.FracBits(FracBits)) u_lane_r (
    .clk_i, .en_i(en), .c_i(g_ctx_q[GDIV].pix.red_in), .ctl_i(lctl), .gain_i(gain),
    .res_o(res_r)
  );

  // side data alongside the two lane stages
  logic l1_v_q, l2_v_q;
  ctx_t l1_ctx_q, l2_ctx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_v_q <= 1'b0;
      l2_v_q <= 1'b0;
    end else if (en) begin
      l1_v_q <= g_v_q[GDIV];
      l2_v_q <= l1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l1_ctx_q <= g_ctx_q[GDIV];
      l2_ctx_q <= l1_ctx_q;
    end
  end

  // merge stage and output word register
  logic     out_v_q;
  pix_out_t out_d, out_q;

  always_comb begin
    if (l2_ctx_q.gray) begin
      out_d.blue_out  = l2_ctx_q.pix.blue_in;
      out_d.green_out = l2_ctx_q.pix.green_in;
      out_d.red_out   = l2_ctx_q.pix.red_in;
    end else begin
      out_d.blue_out  = res_b;
      out_d.green_out = res_g;
      out_d.red_out   = res_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= l2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/hsl_checker.sv =====
// port-level checks for the hsl saturation adjust block
`timescale 1ns / 1ps
module hsl_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic [7:0]        cfg_wdata_i,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input hsl_pkg::pix_in_t  in_word_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input hsl_pkg::pix_out_t out_word_o
);
  logic unused_ports;
  assign unused_ports = cfg_we_i ^ (^cfg_wdata_i) ^ in_valid_i ^ (^in_word_i);

  // a held output word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("held output word changed");

  // input stalls exactly when the output word is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output hold");

  // no stall while the output is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("stall with no pending output word");

endmodule

bind hsl_saturation_adjust hsl_checker u_hsl_checker (.*);
